// ----- rtl/hash_equi_join_engine_defines.svh -----
// Assertion macros for the hash equi-join engine.
// Used by the top level; relies on signals clk and rst_n in scope.
`ifndef HASH_EQUI_JOIN_ENGINE_DEFINES_SVH
`define HASH_EQUI_JOIN_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define HEJ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hash join engine check failed");
`define HEJ_ASSERT_NEXT(lbl, ante, cons) \
  `HEJ_ASSERT(lbl, (ante) |=> (cons))
`else
`define HEJ_ASSERT(lbl, prop)
`define HEJ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/hej_pkg.sv -----
// Shared types and codes of the hash equi-join engine.
// No dependencies.
package hej_pkg;

  // opcodes of an input word
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_PROBE  = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_MATCH     = 3'd0;
  localparam logic [2:0] ST_PROBE_UNM = 3'd1;
  localparam logic [2:0] ST_BUILD_UNM = 3'd2;
  localparam logic [2:0] ST_INSERTED  = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_OVERFLOW  = 3'd5;

  // join modes
  localparam logic [1:0] MODE_INNER = 2'd0;
  localparam logic [1:0] MODE_LEFT  = 2'd1;
  localparam logic [1:0] MODE_RIGHT = 2'd2;
  localparam logic [1:0] MODE_FULL  = 2'd3;

  // most results one probe may give
  localparam int OUT_LIMIT = 16;
  localparam int NW        = 5;

  typedef struct packed {
    logic [2:0] status;
    logic [9:0] build_row;
    logic [9:0] probe_row;
    logic       last;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } emit_t;

endpackage

// ----- rtl/hej_channels.sv -----
// Handshake channels of the hash equi-join engine: input, result, config.
// No dependencies.
interface hej_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] join_key;
  logic [9:0]         row_id;
  modport source (output valid, opcode, join_key, row_id, input ready);
  modport sink   (input valid, opcode, join_key, row_id, output ready);
endinterface

interface hej_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [9:0] build_row;
  logic [9:0] probe_row;
  logic       last;
  modport source (output valid, status, build_row, probe_row, last, input ready);
  modport sink   (input valid, status, build_row, probe_row, last, output ready);
endinterface

interface hej_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] join_mode;
  modport source (output valid, join_mode, input ready);
  modport sink   (input valid, join_mode, output ready);
endinterface

// ----- rtl/hej_bucket.sv -----
// Bucket index unit: unsigned key modulo BUCKETS by reciprocal multiply.
// Two registered multiply stages; done_o follows start_i through v1_r and v2_r.
module hej_bucket #(
  parameter int BUCKETS = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  logic [31:0]                key_i,
  output logic                       done_o,
  output logic [$clog2(BUCKETS)-1:0] bucket_o
);
  localparam int BW = $clog2(BUCKETS);
  localparam int SH = 32 + BW;
  // ceil(2^SH / BUCKETS) gives an exact quotient for every 32-bit key
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [33:0] M  = RECIP[33:0];
  localparam logic [16:0] BB = 17'(BUCKETS);

  logic [65:0] prod_r;
  logic [48:0] qb_r;
  logic [31:0] key_r;
  logic        v1_r, v2_r;
  logic [31:0] q;

  assign q = 32'(prod_r >> SH);

  // stage 1: key times reciprocal, stage 2: quotient times bucket count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start_i;
      v2_r <= v1_r;
    end
    if (start_i) begin
      key_r  <= key_i;
      prod_r <= 66'(key_i) * 66'(M);
    end
    if (v1_r) begin
      qb_r <= 49'(q) * 49'(BB);
    end
  end

  logic [31:0] rem;
  assign rem      = key_r - qb_r[31:0];
  assign bucket_o = rem[BW-1:0];
  assign done_o   = v2_r;
endmodule

// ----- rtl/hej_ctrl.sv -----
// Join sequencer: owns the row memory (key, chain link, visited) and the
// bucket head memory, walks chains for insert and probe. Uses hej_pkg, hej_bucket.
module hej_ctrl #(
  parameter int ROWS        = 1024,
  parameter int MAX_MATCHES = 16,
  parameter int BUCKETS     = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  hej_in_if.sink          in_ch,
  input  logic [1:0]      mode_i,
  output hej_pkg::emit_t  emit_o,
  input  logic            emit_ready_i
);
  localparam int RW = $clog2(ROWS);
  localparam int LW = $clog2(ROWS + 1);
  localparam int BW = $clog2(BUCKETS);
  localparam int MW = $clog2(MAX_MATCHES + 1);
  localparam int WW = 33 + LW;
  localparam int VB = 32 + LW;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HASH, S_HEAD, S_STEP, S_ROW, S_FIN,
    S_INS_A, S_INS_B, S_FLUSH, S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [31:0]         key_r, key_nxt;
  logic [9:0]          rid_r, rid_nxt;
  logic [BW-1:0]       bkt_r, bkt_nxt;
  logic [LW-1:0]       link_r, link_nxt;
  logic [LW-1:0]       tail_r, tail_nxt;
  logic [WW-1:0]       tail_word_r, tail_word_nxt;
  logic [MW-1:0]       same_r, same_nxt;
  logic [hej_pkg::NW-1:0] n_r, n_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [RW-1:0]       pend_row_r, pend_row_nxt;
  hej_pkg::res_t       res_r, res_nxt;
  logic [LW-1:0]       cnt_r, cnt_nxt;
  logic [BW-1:0]       clr_idx_r, clr_idx_nxt;

  // memories
  logic [WW-1:0] row_mem [ROWS];
  logic [LW-1:0] bkt_mem [BUCKETS];
  logic [WW-1:0] row_rd_r;
  logic [LW-1:0] bkt_rd_r;
  logic          row_we, row_re, bkt_we, bkt_re;
  logic [RW-1:0] row_wa, row_ra;
  logic [WW-1:0] row_wd;
  logic [BW-1:0] bkt_wa, bkt_ra;
  logic [LW-1:0] bkt_wd;

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_wa] <= row_wd;
    if (row_re) row_rd_r <= row_mem[row_ra];
  end

  always_ff @(posedge clk) begin
    if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
    if (bkt_re) bkt_rd_r <= bkt_mem[bkt_ra];
  end

  // bucket index unit
  logic          hash_start, hash_done;
  logic [BW-1:0] hash_bkt;

  hej_bucket #(.BUCKETS(BUCKETS)) u_bucket (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (hash_start),
    .key_i    (in_ch.join_key),
    .done_o   (hash_done),
    .bucket_o (hash_bkt)
  );

  logic [RW-1:0] cur_row;
  logic          hit;
  assign cur_row = RW'(link_r - LW'(1));
  assign hit     = (row_rd_r[31:0] == key_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    rid_nxt       = rid_r;
    bkt_nxt       = bkt_r;
    link_nxt      = link_r;
    tail_nxt      = tail_r;
    tail_word_nxt = tail_word_r;
    same_nxt      = same_r;
    n_nxt         = n_r;
    pend_v_nxt    = pend_v_r;
    pend_row_nxt  = pend_row_r;
    res_nxt       = res_r;
    cnt_nxt       = cnt_r;
    clr_idx_nxt   = clr_idx_r;
    in_ch.ready   = 1'b0;
    hash_start    = 1'b0;
    emit_o        = '0;
    row_we = 1'b0; row_wa = '0; row_wd = '0;
    row_re = 1'b0; row_ra = '0;
    bkt_we = 1'b0; bkt_wa = '0; bkt_wd = '0;
    bkt_re = 1'b0; bkt_ra = '0;

    case (state_r)
      // empty every bucket, one per cycle
      S_CLR: begin
        bkt_we = 1'b1;
        bkt_wa = clr_idx_r;
        if (clr_idx_r == BW'(BUCKETS - 1)) state_nxt = S_IDLE;
        else clr_idx_nxt = clr_idx_r + BW'(1);
      end

      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          op_nxt     = in_ch.opcode;
          key_nxt    = in_ch.join_key;
          rid_nxt    = in_ch.row_id;
          same_nxt   = '0;
          n_nxt      = '0;
          pend_v_nxt = 1'b0;
          tail_nxt   = '0;
          case (in_ch.opcode)
            hej_pkg::OP_INSERT: begin
              if (cnt_r == LW'(ROWS)) begin
                res_nxt   = '{hej_pkg::ST_FULL, 10'd0, 10'd0, 1'b1};
                state_nxt = S_EMIT;
              end else begin
                hash_start = 1'b1;
                state_nxt  = S_HASH;
              end
            end
            hej_pkg::OP_PROBE: begin
              hash_start = 1'b1;
              state_nxt  = S_HASH;
            end
            hej_pkg::OP_FLUSH: begin
              row_re    = 1'b1;
              row_ra    = RW'(in_ch.row_id);
              state_nxt = S_FLUSH;
            end
            default: begin
              cnt_nxt     = '0;
              clr_idx_nxt = '0;
              state_nxt   = S_CLR;
            end
          endcase
        end
      end

      S_HASH: begin
        if (hash_done) begin
          bkt_nxt   = hash_bkt;
          bkt_re    = 1'b1;
          bkt_ra    = hash_bkt;
          state_nxt = S_HEAD;
        end
      end

      S_HEAD: begin
        link_nxt  = bkt_rd_r;
        state_nxt = S_STEP;
      end

      // follow the chain while links stay live and a probe is under OUT_LIMIT matches
      S_STEP: begin
        if (link_r != '0 && link_r <= cnt_r &&
            (op_r == hej_pkg::OP_INSERT || n_r < hej_pkg::NW'(hej_pkg::OUT_LIMIT))) begin
          row_re    = 1'b1;
          row_ra    = cur_row;
          state_nxt = S_ROW;
        end else if (op_r == hej_pkg::OP_INSERT) begin
          if (same_r >= MW'(MAX_MATCHES)) begin
            res_nxt   = '{hej_pkg::ST_OVERFLOW, 10'd0, 10'd0, 1'b1};
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_INS_A;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_ROW: begin
        if (op_r == hej_pkg::OP_INSERT) begin
          if (hit && same_r < MW'(MAX_MATCHES)) same_nxt = same_r + MW'(1);
          tail_nxt      = link_r;
          tail_word_nxt = row_rd_r;
          link_nxt      = row_rd_r[VB-1:32];
          state_nxt     = S_STEP;
        end else if (hit) begin
          // push the held match, then hold this one
          emit_o.valid = pend_v_r;
          emit_o.res   = '{hej_pkg::ST_MATCH, 10'(pend_row_r), rid_r, 1'b0};
          if (!pend_v_r || emit_ready_i) begin
            row_we       = 1'b1;
            row_wa       = cur_row;
            row_wd       = {1'b1, row_rd_r[VB-1:0]};
            pend_v_nxt   = 1'b1;
            pend_row_nxt = cur_row;
            n_nxt        = n_r + hej_pkg::NW'(1);
            link_nxt     = row_rd_r[VB-1:32];
            state_nxt    = S_STEP;
          end
        end else begin
          link_nxt  = row_rd_r[VB-1:32];
          state_nxt = S_STEP;
        end
      end

      // close a probe: last match, or null build side in outer modes
      S_FIN: begin
        if (pend_v_r) begin
          emit_o.valid = 1'b1;
          emit_o.res   = '{hej_pkg::ST_MATCH, 10'(pend_row_r), rid_r, 1'b1};
          if (emit_ready_i) state_nxt = S_IDLE;
        end else if (mode_i != hej_pkg::MODE_INNER) begin
          emit_o.valid = 1'b1;
          emit_o.res   = '{hej_pkg::ST_PROBE_UNM, 10'd0, rid_r, 1'b1};
          if (emit_ready_i) state_nxt = S_IDLE;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // new row, and head link when the bucket was empty
      S_INS_A: begin
        row_we = 1'b1;
        row_wa = RW'(cnt_r);
        row_wd = {1'b0, LW'(0), key_r};
        if (tail_r == '0) begin
          bkt_we = 1'b1;
          bkt_wa = bkt_r;
          bkt_wd = cnt_r + LW'(1);
        end
        state_nxt = S_INS_B;
      end

      // append to the tail of a non-empty chain
      S_INS_B: begin
        if (tail_r != '0) begin
          row_we = 1'b1;
          row_wa = RW'(tail_r - LW'(1));
          row_wd = {tail_word_r[VB], cnt_r + LW'(1), tail_word_r[31:0]};
        end
        res_nxt   = '{hej_pkg::ST_INSERTED, 10'(cnt_r), 10'd0, 1'b1};
        cnt_nxt   = cnt_r + LW'(1);
        state_nxt = S_EMIT;
      end

      S_FLUSH: begin
        if (mode_i == hej_pkg::MODE_FULL && 32'(rid_r) < 32'(cnt_r) &&
            32'(rid_r) < 32'(ROWS) && !row_rd_r[VB]) begin
          res_nxt   = '{hej_pkg::ST_BUILD_UNM, rid_r, 10'd0, 1'b1};
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_EMIT: begin
        emit_o.valid = 1'b1;
        emit_o.res   = res_r;
        if (emit_ready_i) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_idx_r <= '0;
      cnt_r     <= '0;
      pend_v_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      cnt_r     <= cnt_nxt;
      pend_v_r  <= pend_v_nxt;
    end
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    rid_r       <= rid_nxt;
    bkt_r       <= bkt_nxt;
    link_r      <= link_nxt;
    tail_r      <= tail_nxt;
    tail_word_r <= tail_word_nxt;
    same_r      <= same_nxt;
    n_r         <= n_nxt;
    pend_row_r  <= pend_row_nxt;
    res_r       <= res_nxt;
  end
endmodule

// ----- rtl/hash_equi_join_engine.sv -----
// Hash equi-join engine on 32-bit keys: insert, probe, flush and clear words
// in, match/unmatched/insert status words out. One word is worked at a time.
// Probe and insert hash the key, read its bucket head and then read the row
// memory once per entry in the key's bucket chain; insert then links the
// row and gives its status. Flush reads one row and may emit, and clear,
// like the sweep after reset, keeps the input stalled while the bucket
// heads are emptied. Output stalls can hold any of these.
// Results pass through an output register, so one result may wait while the
// engine goes on. Config writes are always accepted.
`include "hash_equi_join_engine_defines.svh"
module hash_equi_join_engine #(
  parameter int ROWS        = 1024,
  parameter int MAX_MATCHES = 16,
  parameter int BUCKETS     = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  hej_in_if.sink    in_ch,
  hej_out_if.source out_ch,
  hej_cfg_if.sink   cfg_ch
);
  logic [1:0]     mode_r;
  hej_pkg::emit_t emit;
  logic           emit_ready;
  hej_pkg::res_t  out_r;
  logic           out_v_r;
  logic           ins_out;
  logic           clr_acc;

  // join mode register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= hej_pkg::MODE_INNER;
    else if (cfg_ch.valid) mode_r <= cfg_ch.join_mode;
  end

  hej_ctrl #(
    .ROWS(ROWS), .MAX_MATCHES(MAX_MATCHES), .BUCKETS(BUCKETS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .mode_i       (mode_r),
    .emit_o       (emit),
    .emit_ready_i (emit_ready)
  );

  // output register
  assign emit_ready = !out_v_r || out_ch.ready;
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (emit_ready) out_v_r <= emit.valid;
    if (emit_ready && emit.valid) out_r <= emit.res;
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.status    = out_r.status;
  assign out_ch.build_row = out_r.build_row;
  assign out_ch.probe_row = out_r.probe_row;
  assign out_ch.last      = out_r.last;

  // terms used by the checks
  assign ins_out = out_v_r && (out_r.status == hej_pkg::ST_INSERTED);
  assign clr_acc = in_ch.valid && in_ch.ready && (in_ch.opcode == hej_pkg::OP_CLEAR);

  `HEJ_ASSERT(a_emit_lands, (emit.valid && emit_ready) |=> out_v_r)
  `HEJ_ASSERT(a_insert_no_probe, ins_out |-> (out_r.probe_row == 10'd0))
  `HEJ_ASSERT_NEXT(a_clear_busy, clr_acc, !in_ch.ready)
endmodule
